@@ src/fbai_pkg.sv @@
package fbai_pkg;

  localparam int NSETS  = 7;
  localparam int NRULES = 12;

  typedef logic [NSETS-1:0][8:0] grade_vec_t;
  typedef logic [3:0][7:0] level_vec_t;

  typedef enum logic [1:0] {
    LV_NONE     = 2'd0,
    LV_SOFT     = 2'd1,
    LV_MODERATE = 2'd2,
    LV_HARD     = 2'd3
  } level_sel_t;

  // sets 0..3 grade distance, sets 4..6 grade speed, breakpoints in q8.8
  localparam logic [15:0] SET_LO [NSETS] = '{16'd0, 16'd512, 16'd1536, 16'd2560,
                                             16'd0, 16'd5120, 16'd10240};
  localparam logic [15:0] SET_PK [NSETS] = '{16'd512, 16'd1536, 16'd2560, 16'd3584,
                                             16'd5120, 16'd10240, 16'd15360};
  localparam logic [15:0] SET_HI [NSETS] = '{16'd1536, 16'd2560, 16'd3584, 16'd25600,
                                             16'd10240, 16'd15360, 16'd25600};
  // edge spans in whole units and their 2^16 reciprocals
  localparam logic [6:0] SPAN_R [NSETS] = '{7'd2, 7'd4, 7'd4, 7'd4, 7'd20, 7'd20, 7'd20};
  localparam logic [6:0] SPAN_F [NSETS] = '{7'd4, 7'd4, 7'd4, 7'd86, 7'd20, 7'd20, 7'd40};
  localparam logic [15:0] RECIP_R [NSETS] = '{16'd32768, 16'd16384, 16'd16384, 16'd16384,
                                              16'd3276, 16'd3276, 16'd3276};
  localparam logic [15:0] RECIP_F [NSETS] = '{16'd16384, 16'd16384, 16'd16384, 16'd762,
                                              16'd3276, 16'd3276, 16'd1638};

  localparam logic [2:0] RULE_D [NRULES] = '{3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1,
                                             3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3};
  localparam logic [2:0] RULE_S [NRULES] = '{3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd6,
                                             3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd6};
  localparam level_sel_t RULE_L [NRULES] = '{LV_MODERATE, LV_HARD, LV_HARD,
                                             LV_SOFT, LV_MODERATE, LV_HARD,
                                             LV_NONE, LV_SOFT, LV_MODERATE,
                                             LV_NONE, LV_NONE, LV_SOFT};

  localparam logic [7:0] LEVEL_NONE_RST     = 8'd0;
  localparam logic [7:0] LEVEL_SOFT_RST     = 8'd25;
  localparam logic [7:0] LEVEL_MODERATE_RST = 8'd50;
  localparam logic [7:0] LEVEL_HARD_RST     = 8'd100;

endpackage

@@ src/fbai_grade.sv @@
module fbai_grade import fbai_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [15:0] distance,
  input  logic [15:0] speed,
  output logic       out_valid,
  input  logic       out_ready,
  output grade_vec_t grades
);

  logic v1, v2, v3;
  logic r1, r2, r3;
  logic [14:0] n1 [NSETS];
  logic [14:0] n2 [NSETS];
  logic fall1 [NSETS];
  logic fall2 [NSETS];
  logic zero1 [NSETS];
  logic zero2 [NSETS];
  logic [30:0] p2 [NSETS];
  grade_vec_t g3;

  assign r3 = !v3 || out_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;
  assign out_valid = v3;
  assign grades = g3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  // edge offset and side of the peak
  always_ff @(posedge clk) begin
    if (r1) begin
      for (int j = 0; j < NSETS; j++) begin
        logic [15:0] x;
        x = (j < 4) ? distance : speed;
        zero1[j] <= (x <= SET_LO[j]) || (x >= SET_HI[j]);
        fall1[j] <= x > SET_PK[j];
        n1[j] <= (x > SET_PK[j]) ? 15'(SET_HI[j] - x) : 15'(x - SET_LO[j]);
      end
    end
  end

  // reciprocal multiply
  always_ff @(posedge clk) begin
    if (r2) begin
      for (int j = 0; j < NSETS; j++) begin
        n2[j] <= n1[j];
        fall2[j] <= fall1[j];
        zero2[j] <= zero1[j];
        p2[j] <= 31'(n1[j] * (fall1[j] ? RECIP_F[j] : RECIP_R[j]));
      end
    end
  end

  // quotient correction
  always_ff @(posedge clk) begin
    if (r3) begin
      for (int j = 0; j < NSETS; j++) begin
        logic [8:0] q0;
        logic [6:0] d;
        logic [15:0] rem;
        q0 = p2[j][24:16];
        d = fall2[j] ? SPAN_F[j] : SPAN_R[j];
        rem = 16'({1'b0, n2[j]} - 16'(q0 * d));
        if (zero2[j]) g3[j] <= 9'd0;
        else g3[j] <= (rem >= 16'(d)) ? 9'(q0 + 9'd1) : q0;
      end
    end
  end

endmodule

@@ src/fbai_rules.sv @@
module fbai_rules import fbai_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  grade_vec_t  grades,
  input  level_vec_t  levels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] num,
  output logic [11:0] den
);

  logic v4, v5, v6, v7;
  logic r4, r5, r6, r7;
  logic [8:0] w4 [NRULES];
  logic [8:0] w5 [NRULES];
  logic [16:0] p5 [NRULES];
  logic [18:0] pn6 [3];
  logic [10:0] pd6 [3];
  logic [19:0] num7;
  logic [11:0] den7;

  assign r7 = !v7 || out_ready;
  assign r6 = !v6 || r7;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign in_ready = r4;
  assign out_valid = v7;
  assign num = num7;
  assign den = den7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (r4) v4 <= in_valid;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
      if (r7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      for (int r = 0; r < NRULES; r++) begin
        w4[r] <= (grades[RULE_D[r]] < grades[RULE_S[r]]) ? grades[RULE_D[r]]
                                                          : grades[RULE_S[r]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      for (int r = 0; r < NRULES; r++) begin
        w5[r] <= w4[r];
        p5[r] <= 17'(w4[r] * levels[RULE_L[r]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r6) begin
      for (int k = 0; k < 3; k++) begin
        pn6[k] <= 19'(p5[4*k]) + 19'(p5[4*k+1]) + 19'(p5[4*k+2]) + 19'(p5[4*k+3]);
        pd6[k] <= 11'(w5[4*k]) + 11'(w5[4*k+1]) + 11'(w5[4*k+2]) + 11'(w5[4*k+3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r7) begin
      num7 <= 20'(pn6[0]) + 20'(pn6[1]) + 20'(pn6[2]);
      den7 <= 12'(pd6[0]) + 12'(pd6[1]) + 12'(pd6[2]);
    end
  end

endmodule

@@ src/fbai_div.sv @@
module fbai_div import fbai_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] num,
  input  logic [11:0] den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] quot,
  output logic        zero_den
);

  localparam int NSTG = 16;

  logic        v   [NSTG];
  logic        rdy [NSTG];
  logic [11:0] rem [NSTG];
  logic [15:0] low [NSTG];
  logic [15:0] q   [NSTG];
  logic [11:0] dv  [NSTG];
  logic        zf  [NSTG];

  always_comb begin
    rdy[NSTG-1] = !v[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) rdy[i] = !v[i] || rdy[i+1];
  end

  assign in_ready = rdy[0];
  assign out_valid = v[NSTG-1];
  assign quot = zf[NSTG-1] ? 16'd0 : q[NSTG-1];
  assign zero_den = zf[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTG; i++) v[i] <= 1'b0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) if (rdy[i]) v[i] <= v[i-1];
    end
  end

  // one quotient bit per stage, dividend is num * 256
  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (rdy[i]) begin
        logic [11:0] r_in;
        logic [15:0] l_in;
        logic [15:0] q_in;
        logic [11:0] d_in;
        logic [12:0] t;
        logic ge;
        if (i == 0) begin
          r_in = num[19:8];
          l_in = {num[7:0], 8'd0};
          q_in = 16'd0;
          d_in = den;
          zf[i] <= den == 12'd0;
        end else begin
          r_in = rem[i-1];
          l_in = low[i-1];
          q_in = q[i-1];
          d_in = dv[i-1];
          zf[i] <= zf[i-1];
        end
        t = {r_in, l_in[15]};
        ge = t >= {1'b0, d_in};
        rem[i] <= ge ? 12'(t - {1'b0, d_in}) : t[11:0];
        low[i] <= {l_in[14:0], 1'b0};
        q[i] <= {q_in[14:0], ge};
        dv[i] <= d_in;
      end
    end
  end

endmodule

@@ src/fuzzy_brake_angle_inference_top.sv @@
// fuzzy brake angle inference
// input words arrive on s_tvalid/s_tready/s_tdata: distance in bits 15:0 and
// speed in bits 31:16, both unsigned q8.8. each word gives one result word on
// m_tvalid/m_tready/m_tdata with the brake angle (q8.8) in bits 15:0 and
// m_tuser set when no rule fired (angle then forced to zero).
// the four output levels sit in apb registers at byte addresses 0, 4, 8, 12
// (none, soft, moderate, hard); write them only while the block is idle.
// an accepted input word reaches its result on m_tvalid through 3 grading
// stages, 4 rule and sum stages and a 16 stage divider that retires one
// quotient bit per stage.
// throughput is one word per cycle while m_tready stays high, set by the
// pipeline that moves one word per stage per cycle.
// every stage holds its word while the next stage is full and stalled, so a
// stalled receiver fills the empty stages first and then drops s_tready;
// nothing is lost or repeated.
// synchronous reset empties the pipeline and loads the level registers with
// 0, 25, 50 and 100.
module fuzzy_brake_angle_inference_top import fbai_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // distance, speed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // brake_angle
  output logic        m_tuser,   // no_rule_fired
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  level_vec_t levels;
  grade_vec_t grades;
  logic g_valid, g_ready;
  logic s_valid, s_ready;
  logic [19:0] num;
  logic [11:0] den;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels[LV_NONE]     <= LEVEL_NONE_RST;
      levels[LV_SOFT]     <= LEVEL_SOFT_RST;
      levels[LV_MODERATE] <= LEVEL_MODERATE_RST;
      levels[LV_HARD]     <= LEVEL_HARD_RST;
    end else if (psel && penable && pwrite && pready) begin
      levels[paddr[3:2]] <= pwdata[7:0];
    end
  end

  assign prdata = {24'd0, levels[paddr[3:2]]};

  fbai_grade u_grade (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .distance  (s_tdata[15:0]),
    .speed     (s_tdata[31:16]),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .grades    (grades)
  );

  fbai_rules u_rules (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .grades    (grades),
    .levels    (levels),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .num       (num),
    .den       (den)
  );

  fbai_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .num       (num),
    .den       (den),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .quot      (m_tdata),
    .zero_den  (m_tuser)
  );

endmodule

@@ src/fbai_checker.sv @@
module fbai_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        pready
);

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 16'd0)
    else $error("no rule fired but angle not zero");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= 16'hFF00)
    else $error("angle above full scale");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result word straight after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind fuzzy_brake_angle_inference_top fbai_checker u_fbai_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .pready   (pready)
);
